/* hdl/ultrasonic_echo_ranger_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH
`ifndef SYNTH
`define UER_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define UER_ASSERT_SAME(label, clk, rst, ante, cons)
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/uer_pkg.sv */
package uer_pkg;

   localparam int DIST_W = 16;
   localparam int DIV_W = 8;
   localparam int CNT_W = $clog2(DIST_W);

   localparam logic [1:0] OP_POLL = 2'd0;
   localparam logic [1:0] OP_CAPTURE = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] CSR_ECHO_LIMIT = 2'd0;
   localparam logic [1:0] CSR_TICKS_PER_UNIT = 2'd1;

   localparam logic [15:0] ECHO_LIMIT_RESET = 16'd23200;
   localparam logic [7:0] TICKS_PER_UNIT_RESET = 8'd58;
   localparam logic [15:0] WRAP_BASE = 16'hFFFF;

   typedef enum logic [1:0] {
      PH_TRIGGER,
      PH_WAIT,
      PH_CALC
   } phase_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_WIDTH,
      SEQ_DIV,
      SEQ_DONE
   } seq_state_type;

endpackage

/* hdl/ultrasonic_echo_ranger.sv */
// Channel   Ports                       Transfer when
// request   req_valid / req_ready       both high at a rising edge of clock
// response  rsp_valid / rsp_ready       both high at a rising edge of clock
// config    csr_valid / csr_ready       both high at a rising edge of clock
// A poll that finishes a measurement passes from request to response through the
// echo width step, the shared restoring divider and the presentation of the response.
// Every other request is answered in the cycle after its transfer.
// A request is taken only when the previous response has been transferred.
// Reset is synchronous and clears the phase, the sensor pointer and all stored readings.
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger #(
   parameter int SENSOR_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_capture_value,
   input  logic [1:0]  req_sensor_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_trigger_request,
   output logic [1:0]  rsp_trigger_sensor,
   output logic        rsp_capture_armed,
   output logic        rsp_edge_polarity,
   output logic        rsp_reading_valid,
   output logic [1:0]  rsp_reading_sensor,
   output logic [15:0] rsp_distance,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int SIDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int DW = uer_pkg::DIST_W;
   localparam int VW = uer_pkg::DIV_W;
   localparam int CW = uer_pkg::CNT_W;

   uer_pkg::seq_state_type state_ff, state_in;
   uer_pkg::phase_type phase_ff, phase_in;
   logic [1:0] cur_ff, cur_in;
   logic [SENSOR_COUNT-1:0] first_edge_ff, first_edge_in;
   logic [DW-1:0] start_ff [SENSOR_COUNT];
   logic [DW-1:0] start_in [SENSOR_COUNT];
   logic [DW-1:0] end_ff [SENSOR_COUNT];
   logic [DW-1:0] end_in [SENSOR_COUNT];
   logic [DW-1:0] dist_ff [SENSOR_COUNT];
   logic [DW-1:0] dist_in [SENSOR_COUNT];
   logic [DW-1:0] limit_ff, limit_in;
   logic [VW-1:0] ticks_ff, ticks_in;
   logic [DW-1:0] quot_ff, quot_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic trig_ff, trig_in;
   logic rvalid_ff, rvalid_in;
   logic [1:0] rsens_ff, rsens_in;
   logic [DW-1:0] rdist_ff, rdist_in;

   logic [SIDX_W-1:0] ci;
   logic [VW-1:0] div_eff;
   logic [DW-1:0] width;
   logic [DW-1:0] dividend;
   logic [VW:0] rem_sh;
   logic [VW:0] rem_diff;
   logic rem_ge;
   logic [DW-1:0] quot_step;
   logic [VW-1:0] rem_step;
   logic req_xfer;

   assign req_ready = (state_ff == uer_pkg::SEQ_IDLE);
   assign req_xfer = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == uer_pkg::SEQ_DONE);
   assign rsp_trigger_request = trig_ff;
   assign rsp_trigger_sensor = cur_ff;
   assign rsp_capture_armed = (phase_ff == uer_pkg::PH_WAIT);
   assign rsp_edge_polarity = first_edge_ff[ci];
   assign rsp_reading_valid = rvalid_ff;
   assign rsp_reading_sensor = rsens_ff;
   assign rsp_distance = rdist_ff;

   assign ci = cur_ff[SIDX_W-1:0];
   assign div_eff = (ticks_ff == '0) ? VW'(1) : ticks_ff;
   assign width = (end_ff[ci] >= start_ff[ci]) ? (end_ff[ci] - start_ff[ci])
                : (uer_pkg::WRAP_BASE - start_ff[ci] + end_ff[ci]);
   assign dividend = (width < limit_ff) ? width : '0;
   assign rem_sh = {rem_ff, quot_ff[DW-1]};
   assign rem_diff = rem_sh - {1'b0, div_eff};
   assign rem_ge = (rem_sh >= {1'b0, div_eff});
   assign quot_step = {quot_ff[DW-2:0], rem_ge};
   assign rem_step = rem_ge ? rem_diff[VW-1:0] : rem_sh[VW-1:0];

   always_comb begin
      limit_in = limit_ff;
      ticks_in = ticks_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            uer_pkg::CSR_ECHO_LIMIT: limit_in = csr_wdata;
            uer_pkg::CSR_TICKS_PER_UNIT: ticks_in = csr_wdata[VW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cur_in = cur_ff;
      first_edge_in = first_edge_ff;
      start_in = start_ff;
      end_in = end_ff;
      dist_in = dist_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      trig_in = trig_ff;
      rvalid_in = rvalid_ff;
      rsens_in = rsens_ff;
      rdist_in = rdist_ff;
      unique case (state_ff)
         uer_pkg::SEQ_IDLE: begin
            if (req_xfer) begin
               state_in = uer_pkg::SEQ_DONE;
               trig_in = 1'b0;
               rvalid_in = 1'b0;
               rsens_in = '0;
               rdist_in = '0;
               unique case (req_operation)
                  uer_pkg::OP_POLL: begin
                     if (phase_ff == uer_pkg::PH_CALC) begin
                        state_in = uer_pkg::SEQ_WIDTH;
                     end else if (phase_ff == uer_pkg::PH_TRIGGER) begin
                        trig_in = 1'b1;
                        phase_in = uer_pkg::PH_WAIT;
                     end
                  end
                  uer_pkg::OP_CAPTURE: begin
                     if (phase_ff == uer_pkg::PH_WAIT) begin
                        if (!first_edge_ff[ci]) begin
                           start_in[ci] = req_capture_value;
                           first_edge_in[ci] = 1'b1;
                        end else begin
                           end_in[ci] = req_capture_value;
                           first_edge_in[ci] = 1'b0;
                           phase_in = uer_pkg::PH_CALC;
                        end
                     end
                  end
                  uer_pkg::OP_READ: begin
                     if ({1'b0, req_sensor_index} < 3'(SENSOR_COUNT)) begin
                        rdist_in = dist_ff[req_sensor_index[SIDX_W-1:0]];
                     end
                  end
                  default: ;
               endcase
            end
         end
         uer_pkg::SEQ_WIDTH: begin
            quot_in = dividend;
            rem_in = '0;
            cnt_in = '0;
            state_in = uer_pkg::SEQ_DIV;
         end
         uer_pkg::SEQ_DIV: begin
            quot_in = quot_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) begin
               dist_in[ci] = quot_step;
               rdist_in = quot_step;
               rvalid_in = 1'b1;
               rsens_in = cur_ff;
               cur_in = (cur_ff == 2'(SENSOR_COUNT - 1)) ? 2'd0 : cur_ff + 2'd1;
               phase_in = uer_pkg::PH_TRIGGER;
               state_in = uer_pkg::SEQ_DONE;
            end
         end
         uer_pkg::SEQ_DONE: begin
            if (rsp_ready) begin
               state_in = uer_pkg::SEQ_IDLE;
            end
         end
         default: state_in = uer_pkg::SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uer_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::PH_TRIGGER;
         cur_ff <= '0;
         first_edge_ff <= '0;
         limit_ff <= uer_pkg::ECHO_LIMIT_RESET;
         ticks_ff <= uer_pkg::TICKS_PER_UNIT_RESET;
         cnt_ff <= '0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            dist_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         cur_ff <= cur_in;
         first_edge_ff <= first_edge_in;
         limit_ff <= limit_in;
         ticks_ff <= ticks_in;
         cnt_ff <= cnt_in;
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff <= end_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      trig_ff <= trig_in;
      rvalid_ff <= rvalid_in;
      rsens_ff <= rsens_in;
      rdist_ff <= rdist_in;
   end

   `UER_ASSERT_NEXT(a_div_ends, clock, reset,
      state_ff == uer_pkg::SEQ_DIV && cnt_ff == CW'(DW - 1),
      state_ff == uer_pkg::SEQ_DONE)
   `UER_ASSERT_NEXT(a_calc_poll_divides, clock, reset,
      req_xfer && req_operation == uer_pkg::OP_POLL && phase_ff == uer_pkg::PH_CALC,
      state_ff == uer_pkg::SEQ_WIDTH)
   `UER_ASSERT_SAME(a_reading_rearms, clock, reset,
      rsp_valid && rsp_reading_valid,
      phase_ff == uer_pkg::PH_TRIGGER && !rsp_trigger_request)
   `UER_ASSERT_NEXT(a_second_edge_calc, clock, reset,
      req_xfer && req_operation == uer_pkg::OP_CAPTURE
         && phase_ff == uer_pkg::PH_WAIT && first_edge_ff[ci],
      phase_ff == uer_pkg::PH_CALC && !rsp_capture_armed)

endmodule

/* sim/tb.sv */
typedef struct packed {
   logic        trigger_request;
   logic [1:0]  trigger_sensor;
   logic        capture_armed;
   logic        edge_polarity;
   logic        reading_valid;
   logic [1:0]  reading_sensor;
   logic [15:0] distance;
} ranger_status_type;

class ranger_scoreboard;
   localparam int SENSORS = 4;

   logic [15:0]         echo_limit;
   logic [7:0]          ticks_per_unit;
   uer_pkg::phase_type  phase;
   logic [1:0]          cur_sensor;
   bit                  first_edge[SENSORS];
   logic [15:0]         start_tick[SENSORS];
   logic [15:0]         end_tick[SENSORS];
   logic [15:0]         stored_range[SENSORS];
   ranger_status_type   awaited_status[$];
   int                  failures;

   function new();
      echo_limit = uer_pkg::ECHO_LIMIT_RESET;
      ticks_per_unit = uer_pkg::TICKS_PER_UNIT_RESET;
      phase = uer_pkg::PH_TRIGGER;
      cur_sensor = 2'd0;
      failures = 0;
      for (int i = 0; i < SENSORS; i++) begin
         first_edge[i] = 1'b0;
         start_tick[i] = '0;
         end_tick[i] = '0;
         stored_range[i] = '0;
      end
   endfunction

   function void write_register(logic [1:0] index, logic [15:0] data);
      if (index == uer_pkg::CSR_ECHO_LIMIT) begin
         echo_limit = data;
      end else if (index == uer_pkg::CSR_TICKS_PER_UNIT) begin
         ticks_per_unit = data[7:0];
      end
   endfunction

   function int pending();
      return awaited_status.size();
   endfunction

   function void note_request(logic [1:0] op, logic [15:0] cap, logic [1:0] idx);
      ranger_status_type st;
      logic [16:0]       width;
      logic [7:0]        divisor;
      logic [15:0]       range;
      st = '0;
      case (op)
         uer_pkg::OP_POLL: begin
            if (phase == uer_pkg::PH_CALC) begin
               if (end_tick[cur_sensor] >= start_tick[cur_sensor]) begin
                  width = {1'b0, end_tick[cur_sensor]} - {1'b0, start_tick[cur_sensor]};
               end else begin
                  width = {1'b0, uer_pkg::WRAP_BASE} - {1'b0, start_tick[cur_sensor]}
                        + {1'b0, end_tick[cur_sensor]};
               end
               divisor = (ticks_per_unit == 8'd0) ? 8'd1 : ticks_per_unit;
               range = (width < {1'b0, echo_limit}) ? 16'(width / divisor) : 16'd0;
               stored_range[cur_sensor] = range;
               st.reading_valid = 1'b1;
               st.reading_sensor = cur_sensor;
               st.distance = range;
               cur_sensor = (int'(cur_sensor) + 1 >= SENSORS) ? 2'd0 : cur_sensor + 2'd1;
               phase = uer_pkg::PH_TRIGGER;
            end else if (phase == uer_pkg::PH_TRIGGER) begin
               st.trigger_request = 1'b1;
               phase = uer_pkg::PH_WAIT;
            end
         end
         uer_pkg::OP_CAPTURE: begin
            if (phase == uer_pkg::PH_WAIT) begin
               if (!first_edge[cur_sensor]) begin
                  start_tick[cur_sensor] = cap;
                  first_edge[cur_sensor] = 1'b1;
               end else begin
                  end_tick[cur_sensor] = cap;
                  first_edge[cur_sensor] = 1'b0;
                  phase = uer_pkg::PH_CALC;
               end
            end
         end
         uer_pkg::OP_READ: begin
            st.distance = (int'(idx) < SENSORS) ? stored_range[idx] : 16'd0;
         end
         default: begin
         end
      endcase
      st.trigger_sensor = cur_sensor;
      st.capture_armed = (phase == uer_pkg::PH_WAIT);
      st.edge_polarity = first_edge[cur_sensor];
      awaited_status.push_back(st);
   endfunction

   function void check_status(ranger_status_type got);
      ranger_status_type exp;
      if (awaited_status.size() == 0) begin
         failures++;
         if (failures <= 10) begin
            $display("unexpected response transfer: distance=%h", got.distance);
         end
         return;
      end
      exp = awaited_status.pop_front();
      if (got.trigger_request !== exp.trigger_request
          || got.trigger_sensor !== exp.trigger_sensor
          || got.capture_armed !== exp.capture_armed
          || got.edge_polarity !== exp.edge_polarity
          || got.reading_valid !== exp.reading_valid
          || got.reading_sensor !== exp.reading_sensor
          || got.distance !== exp.distance) begin
         failures++;
         if (failures <= 10) begin
            $display("mismatch expected trig=%b tsen=%0d arm=%b pol=%b rv=%b rsen=%0d dist=%h",
                     exp.trigger_request, exp.trigger_sensor, exp.capture_armed,
                     exp.edge_polarity, exp.reading_valid, exp.reading_sensor, exp.distance);
            $display("         actual   trig=%b tsen=%0d arm=%b pol=%b rv=%b rsen=%0d dist=%h",
                     got.trigger_request, got.trigger_sensor, got.capture_armed,
                     got.edge_polarity, got.reading_valid, got.reading_sensor, got.distance);
         end
      end
   endfunction
endclass

module tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int PHASE_ITEMS = 95;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = 2'd0;
   logic [15:0] req_capture_value = 16'd0;
   logic [1:0]  req_sensor_index = 2'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_trigger_request;
   logic [1:0]  rsp_trigger_sensor;
   logic        rsp_capture_armed;
   logic        rsp_edge_polarity;
   logic        rsp_reading_valid;
   logic [1:0]  rsp_reading_sensor;
   logic [15:0] rsp_distance;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;

   ranger_scoreboard sb = new();
   int burst_left = 0;
   int idle_cycles = 0;
   bit long_stall_go = 1'b0;

   ultrasonic_echo_ranger u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_capture_value(req_capture_value),
      .req_sensor_index(req_sensor_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_trigger_request(rsp_trigger_request),
      .rsp_trigger_sensor(rsp_trigger_sensor),
      .rsp_capture_armed(rsp_capture_armed),
      .rsp_edge_polarity(rsp_edge_polarity),
      .rsp_reading_valid(rsp_reading_valid),
      .rsp_reading_sensor(rsp_reading_sensor),
      .rsp_distance(rsp_distance),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      ranger_status_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.trigger_request = rsp_trigger_request;
         seen.trigger_sensor = rsp_trigger_sensor;
         seen.capture_armed = rsp_capture_armed;
         seen.edge_polarity = rsp_edge_polarity;
         seen.reading_valid = rsp_reading_valid;
         seen.reading_sensor = rsp_reading_sensor;
         seen.distance = rsp_distance;
         sb.check_status(seen);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // The receiver alternates between always ready, half ready and mostly stalled, with one long stall when asked.
   initial begin
      int mode;
      int seg_left;
      mode = 0;
      seg_left = 0;
      forever begin
         @(negedge clock);
         if (long_stall_go) begin
            long_stall_go = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(negedge clock);
         end else begin
            if (seg_left == 0) begin
               mode = $urandom_range(0, 2);
               seg_left = $urandom_range(10, 80);
            end
            seg_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic offer(logic [1:0] op, logic [15:0] cap, logic [1:0] idx);
      req_valid <= 1'b1;
      req_operation <= op;
      req_capture_value <= cap;
      req_sensor_index <= idx;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, cap, idx);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_all_answered();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_registers(logic [15:0] limit, logic [7:0] divisor, bit touch_unused);
      csr_valid <= 1'b1;
      csr_index <= uer_pkg::CSR_ECHO_LIMIT;
      csr_wdata <= limit;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(uer_pkg::CSR_ECHO_LIMIT, limit);
      @(negedge clock);
      csr_index <= uer_pkg::CSR_TICKS_PER_UNIT;
      csr_wdata <= {8'd0, divisor};
      do @(posedge clock); while (!csr_ready);
      sb.write_register(uer_pkg::CSR_TICKS_PER_UNIT, {8'd0, divisor});
      @(negedge clock);
      if (touch_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= 16'($urandom);
         do @(posedge clock); while (!csr_ready);
         sb.write_register(CSR_UNUSED, csr_wdata);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic noise_item();
      offer(2'($urandom_range(0, 3)), 16'($urandom), 2'($urandom_range(0, 3)));
   endtask

   task automatic random_items(int count);
      int          sent;
      int          width;
      logic [15:0] s;
      logic [15:0] e;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 80) begin
            s = 16'($urandom);
            case ($urandom_range(0, 4))
               0: width = $urandom_range(0, 2000);
               1: width = int'(sb.echo_limit) + $urandom_range(0, 2) - 1;
               2: width = (sb.echo_limit == 0) ? 0 : $urandom_range(0, int'(sb.echo_limit) - 1);
               3: width = $urandom_range(0, 65535);
               default: width = 0;
            endcase
            e = s + 16'(width);
            offer(uer_pkg::OP_POLL, 16'($urandom), 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) == 0) noise_item();
            offer(uer_pkg::OP_CAPTURE, s, 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) == 0) noise_item();
            offer(uer_pkg::OP_CAPTURE, e, 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) == 0) noise_item();
            offer(uer_pkg::OP_POLL, 16'($urandom), 2'($urandom_range(0, 3)));
            sent += 4;
         end else begin
            noise_item();
            sent++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer(uer_pkg::OP_READ, 16'h0000, 2'd0);
      offer(uer_pkg::OP_READ, 16'hFFFF, 2'd3);
      offer(OP_UNUSED, 16'hFFFF, 2'd3);
      offer(uer_pkg::OP_CAPTURE, 16'hFFFF, 2'd0);
      offer(uer_pkg::OP_POLL, 16'h0000, 2'd0);
      offer(uer_pkg::OP_POLL, 16'h0000, 2'd0);
      offer(uer_pkg::OP_CAPTURE, 16'h0000, 2'd0);
      offer(uer_pkg::OP_CAPTURE, 16'hFFFF, 2'd0);
      offer(uer_pkg::OP_CAPTURE, 16'h1234, 2'd0);
      offer(uer_pkg::OP_POLL, 16'h0000, 2'd0);
      offer(uer_pkg::OP_POLL, 16'h0000, 2'd0);
      offer(uer_pkg::OP_CAPTURE, 16'hFFF0, 2'd0);
      offer(uer_pkg::OP_CAPTURE, 16'h0010, 2'd0);
      offer(uer_pkg::OP_POLL, 16'h0000, 2'd0);
      offer(uer_pkg::OP_POLL, 16'h0000, 2'd0);
      offer(uer_pkg::OP_CAPTURE, 16'd100, 2'd0);
      offer(uer_pkg::OP_CAPTURE, 16'd100, 2'd0);
      offer(uer_pkg::OP_POLL, 16'h0000, 2'd0);
      offer(uer_pkg::OP_POLL, 16'h0000, 2'd0);
      offer(uer_pkg::OP_CAPTURE, 16'd0, 2'd0);
      offer(uer_pkg::OP_CAPTURE, 16'd23199, 2'd0);
      offer(uer_pkg::OP_POLL, 16'h0000, 2'd0);
      offer(uer_pkg::OP_READ, 16'h0000, 2'd3);
      offer(uer_pkg::OP_READ, 16'h0000, 2'd1);
      offer(uer_pkg::OP_READ, 16'h0000, 2'd2);
      wait_all_answered();

      write_registers(16'd1000, 8'd0, 1'b1);
      random_items(PHASE_ITEMS);
      wait_all_answered();

      write_registers(16'd0, 8'd1, 1'b0);
      random_items(PHASE_ITEMS);
      wait_all_answered();

      write_registers(16'hFFFF, 8'd255, 1'b0);
      long_stall_go = 1'b1;
      random_items(PHASE_ITEMS);
      wait_all_answered();

      write_registers(16'hFFFF, 8'd1, 1'b0);
      random_items(PHASE_ITEMS);
      wait_all_answered();

      write_registers(16'($urandom), 8'($urandom_range(0, 255)), 1'b0);
      random_items(PHASE_ITEMS);
      wait_all_answered();

      repeat (40) @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
